[sv/wfrm_pkg.sv]
`default_nettype none

package wfrm_pkg;

    // Field and datapath widths fixed by the interface.
    localparam int FRAME_W   = 32;
    localparam int FPS_W     = 30;
    localparam int ELAPSED_W = 33;
    localparam int DEN_W     = 33;
    localparam int CFG_IDX_W = 1;

    localparam int HISTORY_DEPTH_DEF = 64;

    localparam logic [FRAME_W-1:0]   RESET_FRAME_NS      = 32'd16666667;
    localparam logic [DEN_W-1:0]     TWO_E9              = 33'd2000000000;
    localparam logic [FRAME_W-1:0]   UPDATE_INTERVAL_RST = 32'd500000000;
    localparam logic [FRAME_W-1:0]   WINDOW_LIMIT_RST    = 32'd1000000000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT    = 1'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_MIN_GO,
        ST_MIN_WAIT,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

[sv/wfrm_if.sv]
`default_nettype none

interface wfrm_in_if;
    logic                           valid;
    logic                           ready;
    logic [wfrm_pkg::FRAME_W-1:0]   frame_time;

    modport source (output valid, output frame_time, input ready);
    modport sink   (input valid, input frame_time, output ready);
endinterface

interface wfrm_out_if;
    logic                           valid;
    logic                           ready;
    logic [wfrm_pkg::FPS_W-1:0]     avg_fps;
    logic [wfrm_pkg::FPS_W-1:0]     min_fps;

    modport source (output valid, output avg_fps, output min_fps, input ready);
    modport sink   (input valid, input avg_fps, input min_fps, output ready);
endinterface

interface wfrm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wfrm_pkg::CFG_IDX_W-1:0] index;
    logic [wfrm_pkg::FRAME_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/wfrm_ram.sv]
`default_nettype none

module wfrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[sv/wfrm_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is valid
// from the cycle o_done pulses until the next start.
module wfrm_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 33
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   n_rem_sh;
    logic             n_ge;

    always_comb begin
        n_rem_sh = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        n_ge     = n_rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
            r_q   <= {r_q[NUM_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

[sv/windowed_frame_rate_meter.sv]
// A word that does not complete an update interval is accepted in the idle state,
// one word per cycle between reports; one that does starts a scan of the whole ring
// and up to three divisions (mean, average rate, minimum rate) on the single shared
// divider, then loads its report into the output register, which can wait for ready.
// No word is accepted from then until the report is loaded.
// Reset runs a pass filling the ring with 16666667; input waits.
`default_nettype none

module windowed_frame_rate_meter #(
    parameter int HISTORY_DEPTH = wfrm_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wfrm_in_if.sink    i_frame,
    wfrm_cfg_if.sink   i_cfg,
    wfrm_out_if.source o_report
);

    // Ring address width, scan counter width (must hold the depth itself),
    // and the width of the sum of every ring entry.
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = wfrm_pkg::FRAME_W + CW;

    wfrm_pkg::t_state r_state;
    wfrm_pkg::t_state n_state;

    // Configuration registers. The port is always ready; writes must only arrive
    // while the block is idle, which the block itself does not enforce.
    logic [wfrm_pkg::FRAME_W-1:0] r_interval;
    logic [wfrm_pkg::FRAME_W-1:0] r_window;

    // Ring write pointer; it also walks the ring during the clearing pass.
    logic [AW-1:0]                  r_widx;
    logic [wfrm_pkg::ELAPSED_W-1:0] r_elapsed;

    // Scan state: the read address counter and a flag that marks the
    // cycle in which the RAM's registered read data belongs to the scan.
    logic [CW-1:0]                r_scan;
    logic                         r_rd_pend;
    logic [SW-1:0]                r_sum;
    logic [CW-1:0]                r_count;
    logic [wfrm_pkg::FRAME_W-1:0] r_longest;

    // Division results.
    logic [wfrm_pkg::FRAME_W-1:0] r_mean;
    logic [wfrm_pkg::FPS_W-1:0]   r_avg;
    logic [wfrm_pkg::FPS_W-1:0]   r_min;

    // Output register; it lets the next word be accepted while a report waits.
    logic                       r_out_valid;
    logic [wfrm_pkg::FPS_W-1:0] r_out_avg;
    logic [wfrm_pkg::FPS_W-1:0] r_out_min;

    logic                           in_acc;
    logic                           cfg_acc;
    logic                           out_load;
    logic [wfrm_pkg::ELAPSED_W-1:0] elapsed_sum;
    logic                           report_due;
    logic                           scan_issue;
    logic                           scan_done;
    logic                           entry_ok;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [wfrm_pkg::FRAME_W-1:0]   ram_wdata;
    logic [wfrm_pkg::FRAME_W-1:0]   ram_rdata;

    logic                           div_start;
    logic [SW-1:0]                  div_num;
    logic [wfrm_pkg::DEN_W-1:0]     div_den;
    logic                           div_done;
    logic [SW-1:0]                  div_quo;

    // Handshakes.
    assign i_frame.ready = (r_state == wfrm_pkg::ST_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign in_acc        = i_frame.valid && i_frame.ready;
    assign cfg_acc       = i_cfg.valid && i_cfg.ready;

    assign o_report.valid   = r_out_valid;
    assign o_report.avg_fps = r_out_avg;
    assign o_report.min_fps = r_out_min;

    // The elapsed time always fits in the frame width, since it is cleared once it reaches
    // the update interval, so its sum with one frame time fits in the accumulator width.
    assign elapsed_sum = r_elapsed + wfrm_pkg::ELAPSED_W'(i_frame.frame_time);
    assign report_due  = elapsed_sum >= wfrm_pkg::ELAPSED_W'(r_interval);

    assign scan_issue = (r_scan != CW'(HISTORY_DEPTH));
    assign scan_done  = !scan_issue && !r_rd_pend;
    assign entry_ok   = (ram_rdata != '0) && (ram_rdata <= r_window);

    assign out_load = (r_state == wfrm_pkg::ST_OUT) && (!r_out_valid || o_report.ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            wfrm_pkg::ST_CLEAR: begin
                if (r_widx == AW'(HISTORY_DEPTH - 1)) begin
                    n_state = wfrm_pkg::ST_IDLE;
                end
            end
            wfrm_pkg::ST_IDLE: begin
                if (in_acc && report_due) begin
                    n_state = wfrm_pkg::ST_SCAN;
                end
            end
            wfrm_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = wfrm_pkg::ST_MEAN_GO;
                end
            end
            wfrm_pkg::ST_MEAN_GO: begin
                // With no valid entry both rates stay zero.
                n_state = (r_count == '0) ? wfrm_pkg::ST_MIN_GO : wfrm_pkg::ST_MEAN_WAIT;
            end
            wfrm_pkg::ST_MEAN_WAIT: begin
                if (div_done) begin
                    n_state = wfrm_pkg::ST_AVG_GO;
                end
            end
            wfrm_pkg::ST_AVG_GO: begin
                n_state = wfrm_pkg::ST_AVG_WAIT;
            end
            wfrm_pkg::ST_AVG_WAIT: begin
                if (div_done) begin
                    n_state = wfrm_pkg::ST_MIN_GO;
                end
            end
            wfrm_pkg::ST_MIN_GO: begin
                n_state = (r_longest == '0) ? wfrm_pkg::ST_OUT : wfrm_pkg::ST_MIN_WAIT;
            end
            wfrm_pkg::ST_MIN_WAIT: begin
                if (div_done) begin
                    n_state = wfrm_pkg::ST_OUT;
                end
            end
            wfrm_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = wfrm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wfrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Ring write port and divider operands per state. The mean is sum over
    // count; each rate is (2e9 + x) / (2x), which rounds 1e9 / x half up.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = i_frame.frame_time;
        div_start = 1'b0;
        div_num   = r_sum;
        div_den   = wfrm_pkg::DEN_W'(r_count);
        case (r_state)
            wfrm_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = wfrm_pkg::RESET_FRAME_NS;
            end
            wfrm_pkg::ST_IDLE: begin
                ram_we = in_acc;
            end
            wfrm_pkg::ST_MEAN_GO: begin
                div_start = (r_count != '0);
            end
            wfrm_pkg::ST_AVG_GO: begin
                div_start = 1'b1;
                div_num   = SW'(wfrm_pkg::TWO_E9 + wfrm_pkg::DEN_W'(r_mean));
                div_den   = {r_mean, 1'b0};
            end
            wfrm_pkg::ST_MIN_GO: begin
                div_start = (r_longest != '0);
                div_num   = SW'(wfrm_pkg::TWO_E9 + wfrm_pkg::DEN_W'(r_longest));
                div_den   = {r_longest, 1'b0};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wfrm_pkg::ST_CLEAR;
            r_interval  <= wfrm_pkg::UPDATE_INTERVAL_RST;
            r_window    <= wfrm_pkg::WINDOW_LIMIT_RST;
            r_widx      <= '0;
            r_elapsed   <= '0;
            r_scan      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_acc) begin
                case (i_cfg.index)
                    wfrm_pkg::CFG_UPDATE_INTERVAL: r_interval <= i_cfg.data;
                    wfrm_pkg::CFG_WINDOW_LIMIT:    r_window   <= i_cfg.data;
                    default:                       r_window   <= r_window;
                endcase
            end

            if (ram_we) begin
                r_widx <= (r_widx == AW'(HISTORY_DEPTH - 1)) ? '0 : r_widx + 1'b1;
            end

            if (in_acc) begin
                r_elapsed <= report_due ? '0 : elapsed_sum;
                r_scan    <= '0;
                r_rd_pend <= 1'b0;
            end else if (r_state == wfrm_pkg::ST_SCAN) begin
                r_rd_pend <= scan_issue;
                if (scan_issue) begin
                    r_scan <= r_scan + 1'b1;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_report.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Accumulation and result registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_longest <= '0;
            r_avg     <= '0;
            r_min     <= '0;
        end else if (r_state == wfrm_pkg::ST_SCAN && r_rd_pend && entry_ok) begin
            r_sum   <= r_sum + SW'(ram_rdata);
            r_count <= r_count + 1'b1;
            if (ram_rdata > r_longest) begin
                r_longest <= ram_rdata;
            end
        end

        if (div_done) begin
            case (r_state)
                wfrm_pkg::ST_MEAN_WAIT: r_mean <= wfrm_pkg::FRAME_W'(div_quo);
                wfrm_pkg::ST_AVG_WAIT:  r_avg  <= wfrm_pkg::FPS_W'(div_quo);
                wfrm_pkg::ST_MIN_WAIT:  r_min  <= wfrm_pkg::FPS_W'(div_quo);
                default:                r_mean <= r_mean;
            endcase
        end

        if (out_load) begin
            r_out_avg <= r_avg;
            r_out_min <= r_min;
        end
    end

    // The ring of recent frame times. The scan reads it at the scan counter;
    // no write happens during a scan, so there is no read-write overlap.
    wfrm_ram #(
        .WIDTH(wfrm_pkg::FRAME_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_scan[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    // One divider shared by the mean and both rate divisions.
    wfrm_div #(
        .NUM_W(SW),
        .DEN_W(wfrm_pkg::DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

endmodule

`default_nettype wire
